// ===== hw/rtl/cghr_pkg.sv =====
// package for the class graph hasse reduction block
// holds sizes, request codes and the controller/datapath command structs
`timescale 1ns / 1ps
`default_nettype none
package cghr_pkg;
   localparam int MaxVertices = 64;
   localparam int MaxClasses  = 32;
   localparam int MaxLinks    = 64;
   localparam int VertW  = 7;
   localparam int ClassW = 5;
   localparam int LinkW  = 6;
   localparam int CountW = 7;

   localparam logic [1:0] REQ_ASSIGN = 2'd0;
   localparam logic [1:0] REQ_EDGE   = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic              map_write;   // write class map at vertex
      logic              map_read;    // read class map for both endpoints
      logic              scan_start;  // clear duplicate flag
      logic              scan_step;   // compare entry scan_idx
      logic              link_append; // append link or set overflow
      logic              reach_clear;
      logic              reach_load;  // or link scan_idx into reach rows
      logic              close_step;  // closure pivot pivot_idx
      logic              mark_step;   // reduction test of link scan_idx
      logic              finish_clear;
      logic [LinkW-1:0]  scan_idx;
      logic [LinkW-1:0]  inner_idx;
      logic [ClassW-1:0] pivot_idx;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic              dup_found;
      logic              same_class;
      logic              vert_ok;
      logic [CountW-1:0] link_count;
      logic              removed;       // link scan_idx is marked removed
      logic              removed_inner; // link inner_idx is marked removed
   } stat_type;
endpackage
`default_nettype wire

// ===== hw/rtl/cghr_datapath.sv =====
// datapath: class map memory, link table, reach matrix, removal marks
// link table reads are registered, so scan, load and mark act in the cycle after their command
// depends on cghr_pkg
`timescale 1ns / 1ps
`default_nettype none
module cghr_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cghr_pkg::cmd_type               cmd,
   input  wire logic [cghr_pkg::VertW-1:0]      vertex,
   input  wire logic [cghr_pkg::VertW-1:0]      target_vertex,
   input  wire logic [cghr_pkg::ClassW-1:0]     class_id,
   output cghr_pkg::stat_type                   stat,
   output logic [cghr_pkg::ClassW-1:0]          link_from,
   output logic [cghr_pkg::ClassW-1:0]          link_to,
   output logic                                 overflow
);
   localparam int NC = cghr_pkg::MaxClasses;
   localparam int NL = cghr_pkg::MaxLinks;
   localparam int CW = cghr_pkg::ClassW;

   logic [CW-1:0] map_mem [cghr_pkg::MaxVertices+1];
   logic [CW-1:0] c1_ff, c2_ff;
   logic [CW-1:0] from_tab [NL];
   logic [CW-1:0] to_tab [NL];
   logic [NC-1:0] reach_ff [NC];
   logic [NL-1:0] removed_ff;
   logic [cghr_pkg::CountW-1:0] count_ff;
   logic ovf_ff, dup_ff, vok_ff;
   logic [CW-1:0] sf_ff, st_ff, jf_ff, jt_ff;
   logic scan_d_ff, load_d_ff, mark_d_ff;
   logic [cghr_pkg::LinkW-1:0] si_d_ff, ji_d_ff;

   // class map memory, read both endpoints
   always_ff @(posedge clock) begin
      if (cmd.map_write && vertex <= cghr_pkg::VertW'(cghr_pkg::MaxVertices))
         map_mem[vertex] <= class_id;
      if (cmd.map_read) begin
         c1_ff <= map_mem[vertex <= cghr_pkg::VertW'(cghr_pkg::MaxVertices) ? vertex : '0];
         c2_ff <= map_mem[target_vertex <= cghr_pkg::VertW'(cghr_pkg::MaxVertices)
                          ? target_vertex : '0];
      end
   end

   // link table entries, registered reads at the scan and inner index
   always_ff @(posedge clock) begin
      if (cmd.link_append && !dup_ff && count_ff < cghr_pkg::CountW'(NL)) begin
         from_tab[count_ff[cghr_pkg::LinkW-1:0]] <= c1_ff;
         to_tab[count_ff[cghr_pkg::LinkW-1:0]]   <= c2_ff;
      end
      sf_ff <= from_tab[cmd.scan_idx];
      st_ff <= to_tab[cmd.scan_idx];
      jf_ff <= from_tab[cmd.inner_idx];
      jt_ff <= to_tab[cmd.inner_idx];
   end

   // commands that use read data, aligned with the registered reads
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_d_ff <= 1'b0; load_d_ff <= 1'b0; mark_d_ff <= 1'b0;
         si_d_ff <= '0; ji_d_ff <= '0;
      end else begin
         scan_d_ff <= cmd.scan_step;
         load_d_ff <= cmd.reach_load;
         mark_d_ff <= cmd.mark_step;
         si_d_ff <= cmd.scan_idx;
         ji_d_ff <= cmd.inner_idx;
      end
   end

   // control state of the link set
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; ovf_ff <= 1'b0; dup_ff <= 1'b0; vok_ff <= 1'b0;
         removed_ff <= '0;
         for (int i = 0; i < NC; i++) reach_ff[i] <= '0;
      end else begin
         if (cmd.map_read)
            vok_ff <= vertex <= cghr_pkg::VertW'(cghr_pkg::MaxVertices) &&
                      target_vertex <= cghr_pkg::VertW'(cghr_pkg::MaxVertices);
         if (cmd.scan_start) dup_ff <= 1'b0;
         if (scan_d_ff && sf_ff == c1_ff && st_ff == c2_ff) dup_ff <= 1'b1;
         if (cmd.link_append && !dup_ff) begin
            if (count_ff < cghr_pkg::CountW'(NL)) count_ff <= count_ff + 1'b1;
            else ovf_ff <= 1'b1;
         end
         if (cmd.reach_clear) begin
            for (int i = 0; i < NC; i++) reach_ff[i] <= '0;
            removed_ff <= '0;
         end
         if (load_d_ff) reach_ff[sf_ff][st_ff] <= 1'b1;
         if (cmd.close_step)
            for (int x = 0; x < NC; x++)
               if (reach_ff[x][cmd.pivot_idx])
                  reach_ff[x] <= reach_ff[x] | reach_ff[cmd.pivot_idx];
         if (mark_d_ff && ji_d_ff != si_d_ff && jf_ff == sf_ff && jt_ff != st_ff
             && reach_ff[jt_ff][st_ff])
            removed_ff[si_d_ff] <= 1'b1;
         if (cmd.finish_clear) begin
            count_ff <= '0; ovf_ff <= 1'b0; removed_ff <= '0;
            for (int i = 0; i < NC; i++) reach_ff[i] <= '0;
         end
      end
   end

   assign stat.dup_found     = dup_ff;
   assign stat.same_class    = c1_ff == c2_ff;
   assign stat.vert_ok       = vok_ff;
   assign stat.link_count    = count_ff;
   assign stat.removed       = removed_ff[cmd.scan_idx];
   assign stat.removed_inner = removed_ff[cmd.inner_idx];
   assign link_from = sf_ff;
   assign link_to   = st_ff;
   assign overflow  = ovf_ff;

   // a link is never appended past the table size
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cghr_pkg::CountW'(NL)) else $error("link count beyond table");
   // overflow only rises while the table is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> count_ff == cghr_pkg::CountW'(NL)) else $error("early overflow");
   // finish clears the table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.finish_clear |=> count_ff == '0 && !ovf_ff) else $error("table not cleared");
endmodule
`default_nettype wire

// ===== hw/rtl/cghr_control.sv =====
// controller state machine: sequences edge scans and the finish passes
// depends on cghr_pkg
`timescale 1ns / 1ps
`default_nettype none
module cghr_control (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [1:0]           req_kind,
   output cghr_pkg::cmd_type         cmd,
   input  wire cghr_pkg::stat_type   stat,
   output logic                      out_valid,
   output logic                      out_last,
   output logic                      out_none,
   input  wire logic                 out_ready
);
   localparam logic [3:0] S_IDLE = 4'd0, S_LOOK = 4'd1, S_SCAN = 4'd2, S_ADD = 4'd3,
      S_LOAD = 4'd4, S_CLOSE = 4'd5, S_MARK = 4'd6, S_EMIT = 4'd7, S_NONE = 4'd8,
      S_DONE = 4'd9, S_AHEAD = 4'd10;
   localparam int LW = cghr_pkg::LinkW;

   logic [3:0] state_ff, state_in;
   logic [LW:0] i_ff, i_in;   // outer index, one bit to reach the count
   logic [LW:0] j_ff, j_in;
   logic [cghr_pkg::ClassW:0] p_ff, p_in;
   logic any_ff, any_in;
   logic [LW:0] cnt;

   assign cnt = stat.link_count;
   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      cmd = '0;
      cmd.scan_idx  = i_ff[LW-1:0];
      cmd.inner_idx = j_ff[LW-1:0];
      cmd.pivot_idx = p_ff[cghr_pkg::ClassW-1:0];
      state_in = state_ff; i_in = i_ff; j_in = j_ff; p_in = p_ff; any_in = any_ff;
      out_valid = 1'b0; out_last = 1'b0; out_none = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            unique case (req_kind)
               cghr_pkg::REQ_ASSIGN: cmd.map_write = 1'b1;
               cghr_pkg::REQ_EDGE: begin
                  cmd.map_read = 1'b1; state_in = S_LOOK;
               end
               cghr_pkg::REQ_FINISH: begin
                  cmd.reach_clear = 1'b1; i_in = '0; state_in = S_LOAD;
               end
               default: ;
            endcase
         end
         S_LOOK: begin
            cmd.scan_start = 1'b1; i_in = '0;
            state_in = (!stat.vert_ok || stat.same_class) ? S_IDLE : S_SCAN;
         end
         S_SCAN: if (i_ff >= cnt) state_in = S_ADD;
            else begin cmd.scan_step = 1'b1; i_in = i_ff + 1'b1; end
         S_ADD: begin cmd.link_append = 1'b1; state_in = S_IDLE; end
         S_LOAD: if (i_ff >= cnt) begin p_in = '0; state_in = S_CLOSE; end
            else begin cmd.reach_load = 1'b1; i_in = i_ff + 1'b1; end
         S_CLOSE: begin
            cmd.close_step = 1'b1; p_in = p_ff + 1'b1;
            if (p_ff == (cghr_pkg::ClassW+1)'(cghr_pkg::MaxClasses - 1)) begin
               i_in = '0; j_in = '0; state_in = S_MARK;
            end
         end
         S_MARK: if (i_ff >= cnt) begin
               i_in = '0; any_in = 1'b0; state_in = S_EMIT;
            end else if (j_ff >= cnt) begin
               j_in = '0; i_in = i_ff + 1'b1;
            end else begin cmd.mark_step = 1'b1; j_in = j_ff + 1'b1; end
         S_EMIT: begin
            // find whether link i is the last survivor by look-ahead over j
            if (i_ff >= cnt) state_in = any_ff ? S_DONE : S_NONE;
            else if (stat.removed) i_in = i_ff + 1'b1;
            else begin
               // hold link i, look ahead with j for another survivor
               j_in = i_ff + 1'b1;
               state_in = S_AHEAD;
            end
         end
         S_AHEAD: begin // look-ahead: scan j for a later survivor
            if (j_ff >= cnt || !stat.removed_inner) begin
               out_valid = 1'b1; out_last = j_ff >= cnt;
               if (out_ready) begin
                  any_in = 1'b1;
                  if (j_ff >= cnt) begin cmd.finish_clear = 1'b1; state_in = S_IDLE; end
                  else begin i_in = j_ff; state_in = S_EMIT; end
               end
            end else j_in = j_ff + 1'b1;
         end
         S_NONE: begin
            out_valid = 1'b1; out_last = 1'b1; out_none = 1'b1;
            if (out_ready) begin cmd.finish_clear = 1'b1; state_in = S_IDLE; end
         end
         S_DONE: begin cmd.finish_clear = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; i_ff <= '0; j_ff <= '0; p_ff <= '0; any_ff <= 1'b0;
      end else begin
         state_ff <= state_in; i_ff <= i_in; j_ff <= j_in; p_ff <= p_in;
         any_ff <= any_in;
      end
   end

   // nothing is accepted while a result is shown
   a_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !req_tready) else $error("accept during emit");
   // a shown result that stalls stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   // link scans stay within the table
   a_idx: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> i_ff < cnt) else $error("scan beyond count");
endmodule
`default_nettype wire

// ===== hw/rtl/class_graph_hasse_reduction.sv =====
// top level of the class graph hasse reduction block
// joins cghr_control and cghr_datapath; depends on cghr_pkg
//
// usage: send assignment items (vertex to class), then edge items, then a
// finish item. an edge scans the stored link table one entry a cycle; an
// edge whose ends share a class or that has a vertex out of range skips the
// scan. finish loads the reach matrix, closes it over all 32 pivots, tests
// every pair of links, then emits the surviving links in insertion order on
// rsp, the last with tlast high. before each survivor is shown, the removed
// links that follow it are passed over in a look-ahead. if none survive,
// one item with no_links set is emitted. items are taken one at a time: the
// input is not ready while an item is at work; a stalled rsp holds its item
// until taken. after finish the link table and overflow clear; the class map
// is kept. reset empties the table and the reach matrix.
`timescale 1ns / 1ps
`default_nettype none
module class_graph_hasse_reduction (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,  // req_type
   input  wire logic [23:0] req_tdata,  // vertex, target_vertex, class_id
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic             rsp_tlast,  // last
   output logic [1:0]       rsp_tuser,  // no_links, overflow
   output logic [15:0]      rsp_tdata   // link_from, link_to
);
   cghr_pkg::cmd_type cmd;
   cghr_pkg::stat_type stat;
   logic [4:0] lf, lt;
   logic ovf, none;

   cghr_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_kind(req_tuser),
      .cmd, .stat, .out_valid(rsp_tvalid), .out_last(rsp_tlast),
      .out_none(none), .out_ready(rsp_tready));

   cghr_datapath u_dp (
      .clock, .reset, .cmd, .vertex(req_tdata[6:0]), .target_vertex(req_tdata[13:7]),
      .class_id(req_tdata[18:14]), .stat, .link_from(lf), .link_to(lt), .overflow(ovf));

   assign rsp_tdata = none ? 16'd0 : {6'd0, lt, lf};
   assign rsp_tuser = {ovf, none};
endmodule
`default_nettype wire
